// ===== hdl/vid_pkg.sv =====
// ----------------------------------------------------------------------------
// vid_pkg
// shared types, constants and the sine table generator for the vibrato stage
// ----------------------------------------------------------------------------
`default_nettype none

package vid_pkg;

    localparam int SMP_W   = 16;
    localparam int CFG_W   = 16;
    localparam int BLEND_W = 15;
    localparam int DEN_W   = 16;
    localparam int NUM_W   = 32;
    localparam int DRY_W   = 31;
    localparam int QUO_W   = 17;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MOD_DEPTH  = 2'd0;
    localparam t_cfg_idx CFG_PHASE_STEP = 2'd1;
    localparam t_cfg_idx CFG_BLEND_GAIN = 2'd2;

    localparam logic [CFG_W-1:0]   RST_MOD_DEPTH  = 16'd256;
    localparam logic [CFG_W-1:0]   RST_PHASE_STEP = 16'd1;
    localparam logic [BLEND_W-1:0] RST_BLEND_GAIN = 15'd16384;

    localparam logic [DEN_W-1:0] DEN_BASE = 16'd16384;

    localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SINE,
        S_TAPA,
        S_TAPB,
        S_MIX,
        S_DIVGO,
        S_DIVW
    } t_state;

    // sine of a 16 bit angle, Q1.15, polynomial per quadrant
    function automatic logic signed [SMP_W-1:0] vid_sine_of_angle(input logic [15:0] ang);
        logic [1:0]  q;
        logic [13:0] r;
        longint      z;
        longint      z2;
        longint      poly;
        longint      t;
        longint      s;
        q    = ang[15:14];
        r    = ang[13:0];
        z    = (q == 2'd0 || q == 2'd2) ? longint'(r) : 64'sd16384 - longint'(r);
        z2   = (z * z) >>> 14;
        poly = 64'sd10512 - ((64'sd1160 * z2) >>> 14);
        t    = 64'sd25736 - ((z2 * poly) >>> 14);
        s    = ((z * t) >>> 14) * 2;
        if (s > 64'sd32767) begin
            s = 64'sd32767;
        end
        if (q >= 2'd2) begin
            s = -s;
        end
        return SMP_W'(s);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/vid_in_if.sv =====
// ----------------------------------------------------------------------------
// vid_in_if
// input sample channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface vid_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ===== hdl/vid_out_if.sv =====
// ----------------------------------------------------------------------------
// vid_out_if
// output sample channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface vid_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/vibrato_interp_delay_top.sv =====
// ----------------------------------------------------------------------------
// vibrato_interp_delay_top
// vibrato stage: modulated fractional delay line with linear interpolation
// ----------------------------------------------------------------------------
// Usage:
//   i_smp carries one Q1.15 sample per request, o_smp returns one blended
//   Q1.15 sample per request. i_cfg_* writes mod_depth (0), phase_step (1)
//   and blend_gain (2); the user must write them only while the block is
//   idle, and the block itself leaves this to the user. One request at a time:
//   the sine ROM gives the LFO value, two taps are read from the single RAM
//   read port, the sample is written into the delay RAM with the second tap
//   read, then a serial divider does the division by (1 + blend).
//   The output register holds the result while the receiver stalls; the next
//   request is still taken and the block waits at the end of the divide
//   until the output register is free.
//   Reset: registers return to their defaults, the write pointer and LFO
//   phase to zero. The delay RAM is not cleared; unwritten slots read as
//   zero through a fill flag until the line has wrapped once.
// ----------------------------------------------------------------------------
`default_nettype none

module vibrato_interp_delay_top
    import vid_pkg::*;
#(
    parameter int LINE_DEPTH      = 256,
    parameter int SINE_TABLE_SIZE = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    vid_in_if.sink                i_smp,
    vid_out_if.source             o_smp,
    input  wire logic             i_cfg_we,
    input  wire t_cfg_idx         i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int AW  = $clog2(LINE_DEPTH);
    localparam int SAW = $clog2(SINE_TABLE_SIZE);
    localparam logic [AW:0] LP_L = (AW+1)'(LINE_DEPTH);

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0]          r_mod_depth;
    logic [CFG_W-1:0]          r_phase_step;
    logic [BLEND_W-1:0]        r_blend;

    logic [15:0]               r_phase;
    logic [AW-1:0]             r_wpos;
    logic                      r_full;

    logic signed [SMP_W-1:0]   r_x;
    logic [15:0]               r_m;
    logic signed [DRY_W-1:0]   r_dry;
    logic [AW-1:0]             r_pos_b;
    logic                      r_fwd_a;
    logic                      r_ok_a;
    logic                      r_fwd_b;
    logic                      r_ok_b;
    logic signed [SMP_W-1:0]   r_a;
    logic signed [NUM_W-1:0]   r_num;
    logic signed [SMP_W-1:0]   r_out;
    logic                      r_ovalid;

    logic                      w_in_ready;
    logic                      w_in_acc;
    logic                      w_div_start;
    logic                      w_load_out;
    logic                      w_div_busy;
    logic signed [SMP_W-1:0]   w_quot;

    logic [31:0]               w_phase_prod;
    logic [SAW-1:0]            w_sine_addr;
    logic signed [SMP_W-1:0]   w_sine;
    logic [15:0]               w_sine_off;
    logic [31:0]               w_m_prod;
    logic signed [DRY_W-1:0]   w_dry;

    logic [AW:0]               w_da;
    logic [AW:0]               w_db_raw;
    logic [AW:0]               w_db;
    logic [AW:0]               w_pa_t;
    logic [AW:0]               w_pb_t;
    logic [AW:0]               w_pa_w;
    logic [AW:0]               w_pb_w;
    logic [AW-1:0]             w_pa;
    logic [AW-1:0]             w_pb;

    logic [AW-1:0]             w_raddr;
    logic                      w_we;
    logic [SMP_W-1:0]          w_rdata;

    logic signed [SMP_W-1:0]   w_a;
    logic signed [SMP_W-1:0]   w_b;
    logic signed [SMP_W:0]     w_bdiff;
    logic signed [25:0]        w_fprod;
    logic signed [24:0]        w_mix;
    logic signed [NUM_W-1:0]   w_num;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_depth  <= RST_MOD_DEPTH;
            r_phase_step <= RST_PHASE_STEP;
            r_blend      <= RST_BLEND_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MOD_DEPTH:  r_mod_depth  <= i_cfg_data;
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                CFG_BLEND_GAIN: r_blend      <= i_cfg_data[BLEND_W-1:0];
                default: ;
            endcase
        end
    end

    // lfo table lookup
    assign w_phase_prod = 32'(r_phase) * 32'(SINE_TABLE_SIZE);
    assign w_sine_addr  = w_phase_prod[16 +: SAW];

    vid_sine_rom #(
        .SIZE (SINE_TABLE_SIZE)
    ) u_sine (
        .i_clk  (i_clk),
        .i_addr (w_sine_addr),
        .o_data (w_sine)
    );

    assign w_sine_off = 16'(32'(w_sine) + 32'sd32768);
    assign w_m_prod   = 32'(r_mod_depth) * 32'(w_sine_off);
    assign w_dry      = DRY_W'($signed({1'b0, r_blend})) * DRY_W'(r_x);

    // tap positions, delay zero is the sample of this request
    assign w_da     = (AW+1)'(r_m[15:8]);
    assign w_db_raw = w_da + (AW+1)'(1);
    assign w_db     = (w_db_raw == LP_L) ? '0 : w_db_raw;
    assign w_pa_t   = {1'b0, r_wpos} + LP_L - w_da;
    assign w_pb_t   = {1'b0, r_wpos} + LP_L - w_db;
    assign w_pa_w   = (w_pa_t >= LP_L) ? w_pa_t - LP_L : w_pa_t;
    assign w_pb_w   = (w_pb_t >= LP_L) ? w_pb_t - LP_L : w_pb_t;
    assign w_pa     = w_pa_w[AW-1:0];
    assign w_pb     = w_pb_w[AW-1:0];

    // delay line
    assign w_raddr = (r_state == S_TAPA) ? w_pa : r_pos_b;
    assign w_we    = (r_state == S_TAPB);

    vid_ram #(
        .WIDTH (SMP_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wpos),
        .i_wdata (r_x),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // interpolation: 256*a + f*(b - a)
    assign w_a     = r_fwd_a ? r_x : (r_ok_a ? signed'(w_rdata) : '0);
    assign w_b     = r_fwd_b ? r_x : (r_ok_b ? signed'(w_rdata) : '0);
    assign w_bdiff = (SMP_W+1)'(w_b) - (SMP_W+1)'(r_a);
    assign w_fprod = $signed({1'b0, r_m[7:0]}) * w_bdiff;
    assign w_mix   = $signed({r_a[SMP_W-1], r_a, 8'b0}) + 25'(w_fprod);
    assign w_num   = NUM_W'($signed({w_mix, 6'b0})) + NUM_W'(r_dry);

    vid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (DEN_BASE + DEN_W'(r_blend)),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_smp.valid) begin
                    n_state = S_SINE;
                end
            end
            S_SINE:  n_state = S_TAPA;
            S_TAPA:  n_state = S_TAPB;
            S_TAPB:  n_state = S_MIX;
            S_MIX:   n_state = S_DIVGO;
            S_DIVGO: begin
                w_div_start = 1'b1;
                n_state     = S_DIVW;
            end
            S_DIVW: begin
                if (!w_div_busy && (!r_ovalid || o_smp.ready)) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_in_acc = w_in_ready && i_smp.valid;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_wpos   <= '0;
            r_full   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_phase <= r_phase + r_phase_step;
            end
            if (r_state == S_MIX) begin
                if (r_wpos == AW'(LINE_DEPTH - 1)) begin
                    r_wpos <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_wpos <= r_wpos + AW'(1);
                end
            end
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_smp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x <= i_smp.sample_in;
        end
        if (r_state == S_SINE) begin
            r_m   <= w_m_prod[31:16];
            r_dry <= w_dry;
        end
        if (r_state == S_TAPA) begin
            r_pos_b <= w_pb;
            r_fwd_a <= (w_da == '0);
            r_ok_a  <= r_full || (w_pa < r_wpos);
            r_fwd_b <= (w_db == '0);
            r_ok_b  <= r_full || (w_pb < r_wpos);
        end
        if (r_state == S_TAPB) begin
            r_a <= w_a;
        end
        if (r_state == S_MIX) begin
            r_num <= w_num;
        end
        if (w_load_out) begin
            r_out <= w_quot;
        end
    end

    assign i_smp.ready      = w_in_ready;
    assign o_smp.valid      = r_ovalid;
    assign o_smp.sample_out = r_out;

    // checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == S_SINE)
        else $error("request taken but sequencer did not start");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");

    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("fill flag dropped");

    a_wpos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MIX |=> r_wpos != $past(r_wpos))
        else $error("write pointer did not advance");

endmodule

`default_nettype wire

// ===== hdl/vid_ram.sv =====
// ----------------------------------------------------------------------------
// vid_ram
// generic single write, single read RAM with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module vid_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/vid_sine_rom.sv =====
// ----------------------------------------------------------------------------
// vid_sine_rom
// constant sine table, Q1.15, one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module vid_sine_rom
    import vid_pkg::*;
#(
    parameter int SIZE = 1024,
    localparam int AW  = $clog2(SIZE)
) (
    input  wire logic                    i_clk,
    input  wire logic        [AW-1:0]    i_addr,
    output logic signed      [SMP_W-1:0] o_data
);

    logic signed [SMP_W-1:0] w_tab [SIZE];
    logic signed [SMP_W-1:0] r_data;

    for (genvar g = 0; g < SIZE; g++) begin : g_tab
        localparam int unsigned ANG = (g * 65536) / SIZE;
        assign w_tab[g] = vid_sine_of_angle(16'(ANG));
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_tab[i_addr];
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== hdl/vid_div.sv =====
// ----------------------------------------------------------------------------
// vid_div
// serial signed divider, one quotient bit per cycle, saturating to 16 bits
// ----------------------------------------------------------------------------
`default_nettype none

module vid_div
    import vid_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [NUM_W-1:0] i_num,
    input  wire logic        [DEN_W-1:0] i_den,
    output logic                         o_busy,
    output logic signed      [SMP_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_n;
    logic [DEN_W-1:0]     r_den;
    logic                 r_neg;

    logic [NUM_W-2:0]     w_mag;
    logic [DEN_W:0]       w_trial;
    logic                 w_ge;
    logic [DEN_W:0]       w_diff;
    logic [QUO_W-1:0]     w_neg_q;

    // magnitude below 2^31, so the top bits start below the divisor
    assign w_mag   = i_num[NUM_W-1] ? (NUM_W-1)'(-i_num) : i_num[NUM_W-2:0];
    assign w_trial = {r_rem, r_n[QUO_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_neg_q = ~r_n + QUO_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QUO_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DEN_W'(w_mag[NUM_W-2:QUO_W]);
            r_n   <= w_mag[QUO_W-1:0];
            r_den <= i_den;
            r_neg <= i_num[NUM_W-1];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_n   <= {r_n[QUO_W-2:0], w_ge};
        end
    end

    always_comb begin
        if (!r_neg) begin
            o_quot = (r_n > QUO_W'(32767)) ? SMP_MAX : signed'(r_n[SMP_W-1:0]);
        end else begin
            o_quot = (r_n > QUO_W'(32768)) ? SMP_MIN : signed'(w_neg_q[SMP_W-1:0]);
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

// ===== sim/vibrato_interp_delay_chk.sv =====
// ----------------------------------------------------------------------------
// vibrato_interp_delay_chk
// watches the sample channels and the register port, predicts each blended
// sample from its own delay line, LFO phase and sine table, and compares
// every returned sample in order against the predicted one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vibrato_interp_delay_chk
    import vid_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    vid_in_if                     i_smp,
    vid_out_if                    i_res,
    input  wire logic             i_cfg_we,
    input  wire t_cfg_idx         i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    output logic [31:0]           o_fail_cnt,
    output logic [31:0]           o_pending
);

    localparam int LINE_LEN  = 256;
    localparam int TABLE_LEN = 1024;

    int                        sine_lut [TABLE_LEN];
    logic signed [SMP_W-1:0]   echo_line [LINE_LEN];
    logic [7:0]                wr_ptr;
    logic [15:0]               lfo_phase;
    logic [CFG_W-1:0]          depth_q8;
    logic [CFG_W-1:0]          lfo_step;
    logic [BLEND_W-1:0]        dry_blend;
    logic signed [SMP_W-1:0]   blended_q [$];
    int unsigned               fail_cnt;

    // Q1.15 sine for one table entry, polynomial per quadrant
    function automatic int lfo_sine_at(input int entry);
        longint ang;
        longint rem;
        longint z;
        longint z2;
        longint poly;
        longint t;
        longint s;
        int     quad;
        ang  = ((longint'(entry) * 65536) / TABLE_LEN) & 64'hFFFF;
        quad = int'(ang >> 14);
        rem  = ang & 64'h3FFF;
        z    = (quad == 0 || quad == 2) ? rem : 64'sd16384 - rem;
        z2   = (z * z) >>> 14;
        poly = 64'sd10512 - ((64'sd1160 * z2) >>> 14);
        t    = 64'sd25736 - ((z2 * poly) >>> 14);
        s    = ((z * t) >>> 14) * 2;
        if (s > 64'sd32767) begin
            s = 64'sd32767;
        end
        return (quad >= 2) ? -int'(s) : int'(s);
    endfunction

    // store the new sample, tap the line at the modulated delay, blend
    function automatic logic signed [SMP_W-1:0] vibrato_next(input logic signed [SMP_W-1:0] x);
        longint     m;
        longint     frac;
        longint     tap_a;
        longint     tap_b;
        longint     num;
        longint     y;
        logic [7:0] pos_a;
        logic [7:0] pos_b;
        echo_line[wr_ptr] = x;
        m     = (longint'(depth_q8) * (32768 + sine_lut[lfo_phase[15:6]])) >>> 16;
        frac  = m & 255;
        pos_a = wr_ptr - 8'(m >>> 8);
        pos_b = pos_a - 8'd1;
        tap_a = longint'(echo_line[pos_a]);
        tap_b = longint'(echo_line[pos_b]);
        num   = ((256 - frac) * tap_a + frac * tap_b) * 64
              + longint'(dry_blend) * longint'(x);
        y     = num / (64'sd16384 + longint'(dry_blend));
        if (y > 64'sd32767) begin
            y = 64'sd32767;
        end
        if (y < -64'sd32768) begin
            y = -64'sd32768;
        end
        lfo_phase = lfo_phase + lfo_step;
        wr_ptr    = wr_ptr + 8'd1;
        return SMP_W'(y);
    endfunction

    initial begin
        for (int i = 0; i < TABLE_LEN; i++) begin
            sine_lut[i] = lfo_sine_at(i);
        end
        fail_cnt   = 0;
        o_fail_cnt = '0;
        o_pending  = '0;
    end

    always @(posedge i_clk) begin
        logic signed [SMP_W-1:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < LINE_LEN; i++) begin
                echo_line[i] = '0;
            end
            wr_ptr    = '0;
            lfo_phase = '0;
            depth_q8  = RST_MOD_DEPTH;
            lfo_step  = RST_PHASE_STEP;
            dry_blend = RST_BLEND_GAIN;
            blended_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MOD_DEPTH:  depth_q8  = i_cfg_data;
                    CFG_PHASE_STEP: lfo_step  = i_cfg_data;
                    CFG_BLEND_GAIN: dry_blend = i_cfg_data[BLEND_W-1:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (blended_q.size() == 0) begin
                    $error("sample_out with no request waiting: got %0d", i_res.sample_out);
                    fail_cnt++;
                end else begin
                    want = blended_q.pop_front();
                    if (i_res.sample_out !== want) begin
                        $error("sample_out mismatch: expected %0d, got %0d",
                               want, i_res.sample_out);
                        fail_cnt++;
                    end
                end
            end
            if (i_smp.valid && i_smp.ready) begin
                blended_q.push_back(vibrato_next(i_smp.sample_in));
            end
        end
        o_fail_cnt <= fail_cnt;
        o_pending  <= blended_q.size();
    end

endmodule

// ===== sim/vibrato_interp_delay_top_tb.sv =====
// ----------------------------------------------------------------------------
// vibrato_interp_delay_top_tb
// drives sample requests and register writes into the vibrato stage: a
// directed set at the register extremes, then phases of random samples under
// random settings, with random gaps on both sides, a quiet phase and a long
// receiver hold-off; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vibrato_interp_delay_top_tb;
    import vid_pkg::*;

    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 104;
    localparam int HOLD_CYCLES   = 400;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int SETTLE_CYCLES = 30;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    t_cfg_idx         cfg_idx;
    logic [CFG_W-1:0] cfg_data;
    logic [31:0]      fail_cnt;
    logic [31:0]      pending;
    bit               quiet;
    bit               hold_req;

    vid_in_if  smp_in ();
    vid_out_if smp_out ();

    vibrato_interp_delay_top u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_smp      (smp_in),
        .o_smp      (smp_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    vibrato_interp_delay_chk u_chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_smp      (smp_in),
        .i_res      (smp_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic push_sample(input logic signed [SMP_W-1:0] x);
        while (!quiet && $urandom_range(99) < 36) begin
            smp_in.valid <= 1'b0;
            @(posedge clk);
        end
        smp_in.valid     <= 1'b1;
        smp_in.sample_in <= x;
        do @(posedge clk); while (!smp_in.ready);
    endtask

    task automatic drain();
        smp_in.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_regs(input logic [CFG_W-1:0] depth, input logic [CFG_W-1:0] step,
                              input logic [BLEND_W-1:0] blend);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MOD_DEPTH;
        cfg_data <= depth;
        @(posedge clk);
        cfg_idx  <= CFG_PHASE_STEP;
        cfg_data <= step;
        @(posedge clk);
        cfg_idx  <= CFG_BLEND_GAIN;
        cfg_data <= CFG_W'(blend);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic signed [SMP_W-1:0] rand_sample();
        int unsigned pick;
        pick = $urandom_range(7);
        case (pick)
            0: return ($urandom_range(1) != 0) ? SMP_MAX : SMP_MIN;
            1: return SMP_W'($urandom_range(512)) - 16'sd256;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    // receiver: random stalls, or one long hold-off on request
    initial begin
        smp_out.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                smp_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                smp_out.ready <= quiet || ($urandom_range(99) >= 36);
            end
        end
    end

    // watchdog on cycles without any accepted request or returned sample
    initial begin
        int unsigned stuck;
        stuck = 0;
        while (stuck < WATCHDOG_MAX) begin
            @(posedge clk);
            if ((smp_in.valid && smp_in.ready) || (smp_out.valid && smp_out.ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic signed [SMP_W-1:0] edge_smp [8];
        logic [CFG_W-1:0]        depth;
        logic [CFG_W-1:0]        step;
        logic [BLEND_W-1:0]      blend;
        int unsigned             pick;

        edge_smp = '{SMP_MAX, SMP_MIN, 16'sd0, -16'sd1, 16'sd1,
                     16'sh5555, 16'shAAAA, 16'sd12345};
        quiet    = 1'b0;
        hold_req = 1'b0;

        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= CFG_MOD_DEPTH;
        cfg_data         <= '0;
        smp_in.valid     <= 1'b0;
        smp_in.sample_in <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults after reset
        foreach (edge_smp[i]) begin
            push_sample(edge_smp[i]);
        end
        drain();

        // zero delay, full step, no dry blend
        write_regs(16'd0, 16'hFFFF, 15'd0);
        for (int i = 0; i < 4; i++) begin
            push_sample(edge_smp[i]);
        end
        drain();

        // delay past the line end, blend above range
        write_regs(16'hFFFF, 16'd16384, 15'h7FFF);
        for (int i = 0; i < 6; i++) begin
            push_sample(edge_smp[i]);
        end
        drain();

        // nominal maximum depth and blend, frozen lfo
        write_regs(16'd51200, 16'd0, 15'd21299);
        for (int i = 0; i < 4; i++) begin
            push_sample(edge_smp[7 - i]);
        end
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            pick = $urandom_range(9);
            case (pick)
                0: depth = 16'd0;
                1: depth = 16'hFFFF;
                2: depth = 16'd51200;
                default: depth = CFG_W'($urandom_range(51200));
            endcase
            pick = $urandom_range(9);
            case (pick)
                0: step = 16'd0;
                1: step = 16'hFFFF;
                2, 3: step = CFG_W'($urandom_range(64, 1));
                default: step = CFG_W'($urandom_range(65535));
            endcase
            pick = $urandom_range(9);
            case (pick)
                0: blend = 15'd0;
                1: blend = 15'h7FFF;
                2: blend = 15'd21299;
                default: blend = BLEND_W'($urandom_range(21299));
            endcase
            write_regs(depth, step, blend);
            quiet = (ph == 3);
            if (ph == 5) begin
                hold_req = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                push_sample(rand_sample());
            end
            drain();
        end
        quiet = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
